FILE: sv/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab intersection core.
// Holds function and face codes, register indexes and the item word layouts.
// No dependencies; every other file but rbsi_div imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

    localparam int unsigned FRAC_W = 16;
    localparam int unsigned DEN_W  = 32;
    localparam int unsigned NUM_W  = DEN_W + FRAC_W;
    localparam int unsigned T_W    = NUM_W + 2;

    localparam logic signed [T_W-1:0] T_INF = {1'b0, {(T_W-1){1'b1}}};
    localparam logic [30:0] DIST_MAX = '1;
    localparam logic signed [T_W-1:0] T_DIST_MAX = T_W'(DIST_MAX);

    localparam logic [1:0] FUNC_CONTAIN = 2'd0;
    localparam logic [1:0] FUNC_ENTRY   = 2'd1;
    localparam logic [1:0] FUNC_EXIT    = 2'd2;

    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_X_MIN = 3'd1;
    localparam logic [2:0] FACE_X_MAX = 3'd2;
    localparam logic [2:0] FACE_Y_MIN = 3'd3;
    localparam logic [2:0] FACE_Y_MAX = 3'd4;
    localparam logic [2:0] FACE_Z_MIN = 3'd5;
    localparam logic [2:0] FACE_Z_MAX = 3'd6;

    localparam logic [2:0] FACE_LO [3] = '{FACE_X_MIN, FACE_Y_MIN, FACE_Z_MIN};
    localparam logic [2:0] FACE_HI [3] = '{FACE_X_MAX, FACE_Y_MAX, FACE_Z_MAX};

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_X_MAX = 3'd1;
    localparam logic [2:0] REG_Y_MIN = 3'd2;
    localparam logic [2:0] REG_Y_MAX = 3'd3;
    localparam logic [2:0] REG_Z_MIN = 3'd4;
    localparam logic [2:0] REG_Z_MAX = 3'd5;
    localparam logic [2:0] REG_PTOL  = 3'd6;
    localparam logic [2:0] REG_CTOL  = 3'd7;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef struct packed {
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
        logic [15:0]      ptol;
        logic [15:0]      ctol;
    } cfg_t;

    typedef struct packed {
        logic       par;
        logic       out_tight;
        logic       out_c;
        logic [2:0] face;
        logic       near_neg;
        logic       far_neg;
    } axis_cls_t;

    typedef struct packed {
        logic [1:0]           func;
        logic                 in_box;
        logic                 contain;
        axis_cls_t [2:0]      ax;
    } item_cls_t;

    typedef struct packed {
        logic [31:0] near_mag;
        logic [31:0] far_mag;
        logic [31:0] dir_mag;
    } axis_ops_t;

    typedef struct packed {
        item_cls_t       cls;
        axis_ops_t [2:0] ops;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: sv/rbsi_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; instantiated by rbsi_back for every slab time.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] den_reg  [NW];

    logic [DW-1:0] rem_in   [NW];
    logic [NW-1:0] num_in   [NW];
    logic [NW-1:0] quo_in   [NW];
    logic [DW-1:0] den_in   [NW];

    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] num_next [NW];
    logic [NW-1:0] quo_next [NW];

    always_comb
    begin
        rem_in[0] = '0;
        num_in[0] = num;
        quo_in[0] = '0;
        den_in[0] = den;
        for (int k = 1; k < NW; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            num_in[k] = num_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            den_in[k] = den_reg[k-1];
        end
    end

    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        for (int k = 0; k < NW; k++)
        begin
            trial = {rem_in[k], num_in[k][NW-1]};
            diff  = trial - {1'b0, den_in[k]};
            ge    = (trial >= {1'b0, den_in[k]});
            rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            num_next[k] = {num_in[k][NW-2:0], 1'b0};
            quo_next[k] = {quo_in[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NW; k++)
        begin
            rem_reg[k] <= rem_next[k];
            num_reg[k] <= num_next[k];
            quo_reg[k] <= quo_next[k];
            den_reg[k] <= den_in[k];
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

`default_nettype wire

FILE: sv/rbsi_front.sv
// Front end: accepts a ray, classifies every axis and forms divider operands.
// Depends on rbsi_pkg; feeds rbsi_queue.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [31:0]  origin_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  rbsi_pkg::cfg_t      cfg,
    input  rbsi_pkg::q_stat_t   q_stat,
    output logic                item_valid,
    output rbsi_pkg::item_t     item
);

    import rbsi_pkg::*;

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int SH = 32 - CW;

    function automatic logic signed [31:0] coord(input logic [31:0] v);
        logic [31:0] s;
        s = v << SH;
        return $signed(s) >>> SH;
    endfunction

    logic signed [31:0] o    [3];
    logic signed [31:0] d    [3];
    logic signed [31:0] lo   [3];
    logic signed [31:0] hi   [3];
    logic signed [32:0] n_lo [3];
    logic signed [32:0] n_hi [3];
    logic [2:0]         in_loose;
    logic [2:0]         out_tight;
    item_t              item_next;

    logic    valid_reg;
    item_t   item_reg;
    logic    accept;

    always_comb
    begin
        logic signed [32:0] o33;
        logic signed [32:0] lo33;
        logic signed [32:0] hi33;
        logic signed [32:0] d_abs;
        logic signed [32:0] near;
        logic signed [32:0] far;
        logic signed [32:0] near_n;
        logic signed [32:0] far_n;
        logic signed [32:0] ptol33;
        logic signed [32:0] ctol33;
        logic               neg;

        o[0]  = coord(origin_x);
        o[1]  = coord(origin_y);
        o[2]  = coord(origin_z);
        d[0]  = coord(dir_x);
        d[1]  = coord(dir_y);
        d[2]  = coord(dir_z);
        ptol33 = $signed({17'b0, cfg.ptol});
        ctol33 = $signed({17'b0, cfg.ctol});
        item_next = '0;
        item_next.cls.func = func;

        for (int i = 0; i < 3; i++)
        begin
            lo[i] = coord(cfg.lo[i]);
            hi[i] = coord(cfg.hi[i]);
            o33   = {o[i][31], o[i]};
            lo33  = {lo[i][31], lo[i]};
            hi33  = {hi[i][31], hi[i]};
            n_lo[i] = lo33 - o33;
            n_hi[i] = hi33 - o33;
            neg   = d[i][31];
            d_abs = neg ? -$signed({d[i][31], d[i]}) : $signed({d[i][31], d[i]});

            out_tight[i] = (o[i] < lo[i]) || (o[i] > hi[i]);
            in_loose[i]  = (o33 > lo33 - ptol33) && (o33 < hi33 + ptol33);

            // Swap the slab bounds for a negative direction so the near time
            // is always the entry and the far time the exit.
            near   = neg ? n_hi[i] : n_lo[i];
            far    = neg ? n_lo[i] : n_hi[i];
            near_n = -near;
            far_n  = -far;

            item_next.cls.ax[i].par       = (d[i] == 32'sd0) || (d_abs < ptol33);
            item_next.cls.ax[i].out_tight = out_tight[i];
            item_next.cls.ax[i].out_c     = (o33 < lo33 - ctol33) || (o33 > hi33 + ctol33);
            item_next.cls.ax[i].face      = neg ? FACE_LO[i] : FACE_HI[i];
            item_next.cls.ax[i].near_neg  = near[32] ^ neg;
            item_next.cls.ax[i].far_neg   = far[32] ^ neg;
            item_next.ops[i].near_mag     = near[32] ? near_n[31:0] : near[31:0];
            item_next.ops[i].far_mag      = far[32] ? far_n[31:0] : far[31:0];
            item_next.ops[i].dir_mag      = d_abs[31:0];
        end

        item_next.cls.in_box  = &in_loose;
        item_next.cls.contain = ~|out_tight;
    end

    assign busy   = valid_reg && q_stat.full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!q_stat.full)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: sv/rbsi_queue.sv
// Short queue between the classifying front end and the arithmetic back end.
// Depends on rbsi_pkg; the back end drains one word per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rbsi_pkg::item_t    in_item,
    output rbsi_pkg::q_stat_t  stat,
    output rbsi_pkg::item_t    out_item
);

    import rbsi_pkg::*;

    item_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic                push;
    logic                pop;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push = in_valid && !stat.full;
    assign pop  = !stat.empty;

    always_comb
    begin
        count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign out_item = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: sv/rbsi_back.sv
// Back end: six pipelined slab dividers, then one resolve stage per axis.
// Depends on rbsi_pkg and rbsi_div; takes words from rbsi_queue.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rbsi_pkg::q_stat_t  q_stat,
    input  rbsi_pkg::item_t    item,
    input  logic [15:0]        ctol,
    output logic               done,
    output logic               hit,
    output logic [30:0]        distance,
    output logic [2:0]         face
);

    import rbsi_pkg::*;

    typedef struct packed {
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        logic                  ok;
        logic [2:0]            face;
    } res_state_t;

    typedef struct packed {
        item_cls_t             cls;
        logic [2:0][T_W-1:0]   tn;
        logic [2:0][T_W-1:0]   tf;
        res_state_t            st;
    } stage_t;

    logic [NUM_W-1:0] q_near [3];
    logic [NUM_W-1:0] q_far  [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbsi_div #(.NW(NUM_W), .DW(DEN_W)) u_near (
            .clk (clk),
            .num ({item.ops[a].near_mag, {FRAC_W{1'b0}}}),
            .den (item.ops[a].dir_mag),
            .quo (q_near[a])
        );
        rbsi_div #(.NW(NUM_W), .DW(DEN_W)) u_far (
            .clk (clk),
            .num ({item.ops[a].far_mag, {FRAC_W{1'b0}}}),
            .den (item.ops[a].dir_mag),
            .quo (q_far[a])
        );
    end

    // One axis of the slab walk; the inside-origin exit search is a separate branch.
    function automatic res_state_t axis_step(
        input res_state_t            s,
        input axis_cls_t             a,
        input logic [1:0]            fn,
        input logic                  in_box,
        input logic signed [T_W-1:0] t0,
        input logic signed [T_W-1:0] t1,
        input logic signed [T_W-1:0] ct
    );
        res_state_t            r;
        logic signed [T_W-1:0] cur_min;
        logic signed [T_W-1:0] cur_max;
        logic signed [T_W-1:0] new_min;
        logic signed [T_W-1:0] new_max;
        r       = s;
        cur_min = s.tmin;
        cur_max = s.tmax;
        if (fn == FUNC_EXIT && in_box)
        begin
            if (!a.par && (t1 > ct) && (t1 < cur_max))
            begin
                r.tmax = t1;
                r.face = a.face;
            end
        end
        else if (a.par)
        begin
            if ((fn == FUNC_ENTRY) ? a.out_tight : a.out_c)
            begin
                r.ok = 1'b0;
            end
        end
        else
        begin
            new_min = (t0 > cur_min) ? t0 : cur_min;
            new_max = cur_max;
            if (t1 < cur_max)
            begin
                new_max = t1;
                r.face  = a.face;
            end
            r.tmin = new_min;
            r.tmax = new_max;
            if ((fn == FUNC_ENTRY) ? (new_max <= new_min) : (new_max <= new_min + ct))
            begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

    item_cls_t        sb_reg [NUM_W];
    logic [NUM_W-1:0] sb_valid_reg;

    stage_t           stg_reg  [4];
    stage_t           stg_next [4];
    logic [3:0]       stg_valid_reg;

    logic signed [T_W-1:0] ct;
    logic                  hit_next;
    logic [30:0]           dist_next;
    logic [2:0]            face_next;
    logic                  done_reg;
    logic                  hit_reg;
    logic [30:0]           dist_reg;
    logic [2:0]            face_reg;

    assign ct = $signed({{(T_W-16){1'b0}}, ctol});

    always_comb
    begin
        logic signed [T_W-1:0] qn;
        logic signed [T_W-1:0] qf;
        stg_next[0].cls     = sb_reg[NUM_W-1];
        stg_next[0].st.tmin = '0;
        stg_next[0].st.tmax = T_INF;
        stg_next[0].st.ok   = 1'b1;
        stg_next[0].st.face = FACE_NONE;
        for (int a = 0; a < 3; a++)
        begin
            qn = $signed({2'b00, q_near[a]});
            qf = $signed({2'b00, q_far[a]});
            stg_next[0].tn[a] = sb_reg[NUM_W-1].ax[a].near_neg ? -qn : qn;
            stg_next[0].tf[a] = sb_reg[NUM_W-1].ax[a].far_neg ? -qf : qf;
        end
        for (int s = 0; s < 3; s++)
        begin
            stg_next[s+1]    = stg_reg[s];
            stg_next[s+1].st = axis_step(stg_reg[s].st, stg_reg[s].cls.ax[s],
                                         stg_reg[s].cls.func, stg_reg[s].cls.in_box,
                                         $signed(stg_reg[s].tn[s]),
                                         $signed(stg_reg[s].tf[s]), ct);
        end
    end

    always_comb
    begin
        stage_t                f;
        logic signed [T_W-1:0] dv;
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        f         = stg_reg[3];
        tmin      = f.st.tmin;
        tmax      = f.st.tmax;
        hit_next  = 1'b0;
        face_next = FACE_NONE;
        dv        = T_INF;
        case (f.cls.func)
            FUNC_CONTAIN:
            begin
                hit_next = f.cls.contain;
                dv       = '0;
            end
            FUNC_ENTRY:
            begin
                hit_next = f.st.ok;
                dv       = f.st.ok ? tmin : T_INF;
            end
            FUNC_EXIT:
            begin
                if (f.cls.in_box || f.st.ok)
                begin
                    face_next = f.st.face;
                    dv        = tmax;
                end
                hit_next = (face_next != FACE_NONE);
                if (!hit_next)
                begin
                    dv = T_INF;
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
        if (dv < 0)
        begin
            dist_next = '0;
        end
        else if (dv > T_DIST_MAX)
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = dv[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg  <= '0;
            stg_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            sb_valid_reg  <= {sb_valid_reg[NUM_W-2:0], !q_stat.empty};
            stg_valid_reg <= {stg_valid_reg[2:0], sb_valid_reg[NUM_W-1]};
            done_reg      <= stg_valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= item.cls;
        for (int k = 1; k < NUM_W; k++)
        begin
            sb_reg[k] <= sb_reg[k-1];
        end
        for (int s = 0; s < 4; s++)
        begin
            stg_reg[s] <= stg_next[s];
        end
        hit_reg  <= hit_next;
        dist_reg <= dist_next;
        face_reg <= face_next;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = dist_reg;
    assign face     = face_reg;

endmodule

`default_nettype wire

FILE: sv/ray_box_slab_intersect_core.sv
// Top level of the ray versus axis-aligned box slab intersection core.
// Depends on rbsi_pkg, rbsi_front, rbsi_queue, rbsi_div and rbsi_back.
//
//   Channel   Handshake               Payload
//   ray in    start / busy            func, origin_x/y/z, dir_x/y/z
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//   result    done (strobe)           hit, distance, face
//
// One ray is taken every cycle while busy is low; the done strobe follows the
// accepting edge through the front register, the queue, the 48 divider stages,
// a quotient sign stage, one resolve stage per axis and the output register.
// Reset clears the control state and loads the box registers with zero and
// both tolerances with one. busy rises only when the two word queue is full,
// which does not happen while the back end drains a word every cycle.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_core #(
    parameter int COORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic               hit,
    output logic [30:0]        distance,
    output logic [2:0]         face
);

    import rbsi_pkg::*;

    logic [2:0][31:0] lo_reg;
    logic [2:0][31:0] hi_reg;
    logic [15:0]      ptol_reg;
    logic [15:0]      ctol_reg;
    cfg_t             cfg;
    q_stat_t          q_stat;
    logic             f_valid;
    item_t            f_item;
    item_t            q_item;
    logic             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= '0;
            hi_reg   <= '0;
            ptol_reg <= 16'd1;
            ctol_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_MIN: lo_reg[0] <= cfg_data;
                REG_X_MAX: hi_reg[0] <= cfg_data;
                REG_Y_MIN: lo_reg[1] <= cfg_data;
                REG_Y_MAX: hi_reg[1] <= cfg_data;
                REG_Z_MIN: lo_reg[2] <= cfg_data;
                REG_Z_MAX: hi_reg[2] <= cfg_data;
                REG_PTOL:  ptol_reg  <= cfg_data[15:0];
                REG_CTOL:  ctol_reg  <= cfg_data[15:0];
                default:   ptol_reg  <= ptol_reg;
            endcase
        end
    end

    assign cfg.lo   = lo_reg;
    assign cfg.hi   = hi_reg;
    assign cfg.ptol = ptol_reg;
    assign cfg.ctol = ctol_reg;

    rbsi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .cfg        (cfg),
        .q_stat     (q_stat),
        .item_valid (f_valid),
        .item       (f_item)
    );

    rbsi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .in_item  (f_item),
        .stat     (q_stat),
        .out_item (q_item)
    );

    rbsi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .item     (q_item),
        .ctol     (ctol_reg),
        .done     (done),
        .hit      (hit),
        .distance (distance),
        .face     (face)
    );

    // A miss reports no face, and either the saturated distance or the zero
    // distance of a containment test.
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (face == FACE_NONE) && ((distance == DIST_MAX) || (distance == '0)))
        else $error("miss result carries a face or a finite distance");

    // A reported face only comes with a hit.
    a_face_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && (face != FACE_NONE) |-> hit)
        else $error("face reported without a hit");

    // busy can only appear while the front register holds an earlier ray.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $past(start) || $past(busy))
        else $error("busy raised with no ray held");

endmodule

`default_nettype wire
